// ----- rtl/core/bscu_pkg.sv -----
`timescale 1ns / 1ps

package bscu_pkg;

  localparam int unsigned ByteBits = 8;

  localparam logic [3:0] FullCount = 4'd8;
  localparam logic [7:0] FullMask  = 8'hFF;

  typedef struct packed {
    logic [7:0] src_byte;
    logic [3:0] bit_count;
    logic       is_absent;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] out_valid_bits;
    logic       out_last;
  } result_t;

  // up to two results from one item, first one in r0
  typedef struct packed {
    logic       valid;
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- rtl/core/bscu_if.sv -----
`timescale 1ns / 1ps

interface bscu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic [3:0] bit_count;
  logic       is_absent;
  logic       flush;

  modport source (output valid, src_byte, bit_count, is_absent, flush, input ready);
  modport sink   (input valid, src_byte, bit_count, is_absent, flush, output ready);
endinterface

interface bscu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] out_valid_bits;
  logic       out_last;

  modport source (output valid, out_byte, out_valid_bits, out_last, input ready);
  modport sink   (input valid, out_byte, out_valid_bits, out_last, output ready);
endinterface

// ----- rtl/core/bitmap_segment_concatenator_unit.sv -----
`timescale 1ns / 1ps
// A result beat passes through the pack stage register and then the result buffer.
// Throughput: one input beat per cycle while each item yields at most one byte
// and the output is ready; a flush that yields two bytes holds the input back
// until the single output port has drained the two-entry result buffer.
// Reset: clears the pending bits, the stage valid and the result buffer.

module bitmap_segment_concatenator_unit
  import bscu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  bscu_in_if.sink      in_i,
  bscu_out_if.source   out_o
);

  in_item_t item;
  push_t    push;
  logic     push_accept;
  result_t  res;

  assign item.src_byte  = in_i.src_byte;
  assign item.bit_count = in_i.bit_count;
  assign item.is_absent = in_i.is_absent;
  assign item.flush     = in_i.flush;

  bscu_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .item_i        (item),
    .push_o        (push),
    .push_accept_i (push_accept)
  );

  bscu_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_accept_o (push_accept),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_res_o     (res)
  );

  assign out_o.out_byte       = res.out_byte;
  assign out_o.out_valid_bits = res.out_valid_bits;
  assign out_o.out_last       = res.out_last;

endmodule

// ----- rtl/core/bscu_pack.sv -----
`timescale 1ns / 1ps

module bscu_pack
  import bscu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t item_i,
  output push_t    push_o,
  input  logic     push_accept_i
);

  logic       s1_valid_q, s1_valid_d;
  in_item_t   item_q;
  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;

  logic [3:0]  n_clip;
  logic [3:0]  cnt_ext;
  logic [7:0]  mask;
  logic [7:0]  new_bits;
  logic [15:0] word;
  logic [3:0]  total;
  logic        full;
  logic [7:0]  acc_nx;
  logic [2:0]  cnt_nx;
  result_t     full_res, tail_res;
  logic        accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || push_accept_i;

  // merge the new bits below the pending ones
  assign n_clip   = (item_q.bit_count > FullCount) ? FullCount : item_q.bit_count;
  assign cnt_ext  = {1'b0, pend_cnt_q};
  assign mask     = 8'(FullMask << (FullCount - n_clip));
  assign new_bits = item_q.is_absent ? 8'h00 : (item_q.src_byte & mask);
  assign word     = {pend_bits_q, 1'b0, 8'h00} | 16'(16'(new_bits) << (FullCount - cnt_ext));
  assign total    = cnt_ext + n_clip;
  assign full     = (total >= FullCount);
  assign acc_nx   = full ? word[7:0] : word[15:8];
  assign cnt_nx   = full ? 3'(total - FullCount) : total[2:0];

  always_comb begin
    full_res.out_byte       = word[15:8];
    full_res.out_valid_bits = FullCount;
    full_res.out_last       = 1'b0;
    tail_res.out_byte       = acc_nx;
    tail_res.out_valid_bits = {1'b0, cnt_nx};
    tail_res.out_last       = 1'b1;

    push_o.valid = s1_valid_q;
    push_o.r0    = full_res;
    push_o.r1    = tail_res;
    push_o.num   = full ? 2'd1 : 2'd0;
    if (item_q.flush) begin
      if (cnt_nx != 3'd0) begin
        if (full) begin
          push_o.num = 2'd2;
        end else begin
          push_o.r0  = tail_res;
          push_o.num = 2'd1;
        end
      end else if (full) begin
        // stream ends on a byte boundary: tag the full byte as last
        push_o.r0.out_last = 1'b1;
      end else begin
        // nothing pending: bare end marker
        push_o.r0  = tail_res;
        push_o.num = 2'd1;
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (push_accept_i) begin
      s1_valid_d = 1'b0;
      if (item_q.flush) begin
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end else begin
        pend_bits_d = acc_nx[7:1];
        pend_cnt_d  = cnt_nx;
      end
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/core/bscu_obuf.sv -----
`timescale 1ns / 1ps

module bscu_obuf
  import bscu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    push_accept_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    e0_q, e0_d;
  result_t    e1_q, e1_d;
  logic       pop;
  logic [1:0] base;
  logic [1:0] free;

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_res_o     = e0_q;
  assign pop           = out_valid_o && out_ready_i;
  assign base          = pop ? 2'(cnt_q - 2'd1) : cnt_q;
  assign free          = 2'(2'd2 - base);
  assign push_accept_o = push_i.valid && (push_i.num <= free);

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = base;
    if (pop) begin
      e0_d = e1_q;
    end
    if (push_accept_o) begin
      cnt_d = 2'(base + push_i.num);
      if (base == 2'd0) begin
        e0_d = push_i.r0;
        e1_d = push_i.r1;
      end else if (base == 2'd1) begin
        e1_d = push_i.r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule
